// ----- rtl/mrme_pkg.sv -----
package mrme_pkg;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_APPEND = 3'd1;
  localparam logic [2:0] OP_SORT   = 3'd2;
  localparam logic [2:0] OP_FIXUP  = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // One table entry as it sits in the RAM.
  typedef struct packed {
    logic [7:0]  mtype;
    logic [63:0] start;
    logic [63:0] size;
  } entry_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  range_type;
    logic [63:0] range_base;
    logic [63:0] range_size;
    logic [4:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [63:0] entry_base;
    logic [63:0] entry_size;
    logic [7:0]  entry_type;
    logic [5:0]  entry_count;
    logic [1:0]  status;
  } rsp_t;

  // Decisions of the shared evaluation unit.
  typedef struct packed {
    logic        del;
    logic        split;
    logic        merge;
    logic        lt;
    entry_t      lower;
    entry_t      upper;
    entry_t      fix;
    logic [63:0] merged_end;
    logic [63:0] rd_end;
  } eval_t;

endpackage

// ----- rtl/mrme_chan.sv -----
interface mrme_chan #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/memory_range_map_engine_core.sv -----
// An add carves the new range out of the table, appends it, then sorts and merges.
// One word is worked at a time; the next is taken once the result has moved to the
// output register. The table lives in single-read, single-write RAM, walked by the
// sequencer one entry per step.
// Reset clears the entry count and the output valid; the table contents stay undefined.
module memory_range_map_engine_core #(
  parameter int MAX_ENTRIES = 32
) (
  input logic     clk,
  input logic     rst,
  mrme_chan.sink   req,
  mrme_chan.source rsp
);
  import mrme_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int XW = (CW > 5) ? CW : 5;
  localparam int EW = $bits(entry_t);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CV_RD  = 5'd1;
  localparam logic [4:0] S_CV_LD  = 5'd2;
  localparam logic [4:0] S_CV_DC  = 5'd3;
  localparam logic [4:0] S_CV_UP  = 5'd4;
  localparam logic [4:0] S_APP    = 5'd5;
  localparam logic [4:0] S_SO_IRD = 5'd6;
  localparam logic [4:0] S_SO_ILD = 5'd7;
  localparam logic [4:0] S_SO_JRD = 5'd8;
  localparam logic [4:0] S_SO_JLD = 5'd9;
  localparam logic [4:0] S_SO_JDC = 5'd10;
  localparam logic [4:0] S_MG_RD0 = 5'd11;
  localparam logic [4:0] S_MG_LD0 = 5'd12;
  localparam logic [4:0] S_MG_RD  = 5'd13;
  localparam logic [4:0] S_MG_LD  = 5'd14;
  localparam logic [4:0] S_MG_DC  = 5'd15;
  localparam logic [4:0] S_FX_RD  = 5'd16;
  localparam logic [4:0] S_FX_LD  = 5'd17;
  localparam logic [4:0] S_FX_DC  = 5'd18;
  localparam logic [4:0] S_RD_RD  = 5'd19;
  localparam logic [4:0] S_RD_LD  = 5'd20;
  localparam logic [4:0] S_DONE   = 5'd21;

  // Control state.
  logic [4:0]    state;
  logic          bank;
  logic [CW-1:0] count;
  logic [CW-1:0] vc;
  logic [CW-1:0] p;
  logic [CW-1:0] j;
  logic [CW-1:0] w;
  logic          rsp_valid;

  // Payload state.
  logic [2:0]  op;
  logic [7:0]  arg_type;
  logic [63:0] arg_start;
  logic [63:0] arg_size;
  logic [63:0] arg_end;
  logic [4:0]  idx;
  logic [1:0]  stat;
  entry_t      h;
  logic [63:0] h_end;
  entry_t      a;
  logic [63:0] a_end;
  rsp_t        rsp_data;

  // RAM ports. The table lives in the bank that bank selects; a carve streams
  // it into the other bank and then flips.
  logic          we;
  logic          wr_other;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [AW-1:0] raddr;
  logic [EW-1:0] rdata0, rdata1;
  entry_t        rd;
  logic          we0, we1;
  eval_t         ev;

  logic [XW-1:0] idx_x;
  logic [XW-1:0] count_x;
  logic [CW:0]   p_inc;
  logic [CW+5:0] count_w;
  entry_t        h_out;

  assign rd      = bank ? entry_t'(rdata1) : entry_t'(rdata0);
  assign we0     = we && ((bank ^ wr_other) == 1'b0);
  assign we1     = we && ((bank ^ wr_other) == 1'b1);
  assign idx_x   = XW'(idx);
  assign count_x = XW'(count);
  assign p_inc   = {1'b0, p} + (CW+1)'(1);
  assign count_w = (CW+6)'(count);

  // The holder with its size rebuilt from its running end.
  always_comb begin
    h_out      = h;
    h_out.size = h_end - h.start;
  end

  mrme_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_ram0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata0)
  );

  mrme_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_ram1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata1)
  );

  mrme_eval u_eval (
    .rd        (rd),
    .a         (a),
    .a_end     (a_end),
    .h         (h),
    .h_end     (h_end),
    .arg_start (arg_start),
    .arg_end   (arg_end),
    .ev        (ev)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // RAM access for the current step.
  always_comb begin
    we       = 1'b0;
    wr_other = 1'b0;
    waddr    = p[AW-1:0];
    wdata    = a;
    raddr    = p[AW-1:0];
    unique case (state)
      S_CV_DC: begin
        if (!ev.del) begin
          we       = 1'b1;
          wr_other = 1'b1;
          waddr    = w[AW-1:0];
          wdata    = ev.lower;
        end
      end
      S_CV_UP: begin
        we       = 1'b1;
        wr_other = 1'b1;
        waddr    = w[AW-1:0] + AW'(1);
        wdata    = ev.upper;
      end
      S_APP: begin
        we          = (count < CW'(MAX_ENTRIES));
        waddr       = count[AW-1:0];
        wdata.mtype = arg_type;
        wdata.start = arg_start;
        wdata.size  = arg_size;
      end
      S_SO_JRD: begin
        raddr = j[AW-1:0];
        if (j == count) begin
          we    = 1'b1;
          waddr = p[AW-1:0];
          wdata = h;
        end
      end
      S_SO_JDC: begin
        we    = ev.lt;
        waddr = j[AW-1:0];
        wdata = h;
      end
      S_MG_RD0: begin
        raddr = '0;
      end
      S_MG_RD: begin
        if (p == count) begin
          we    = 1'b1;
          waddr = w[AW-1:0];
          wdata = h_out;
        end
      end
      S_MG_DC: begin
        we    = !ev.merge;
        waddr = w[AW-1:0];
        wdata = h_out;
      end
      S_FX_DC: begin
        we    = 1'b1;
        wdata = ev.fix;
      end
      S_RD_RD: begin
        raddr = idx_x[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bank      <= 1'b0;
      count     <= '0;
      vc        <= '0;
      p         <= '0;
      j         <= '0;
      w         <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op        <= req.data.op;
            arg_type  <= req.data.range_type;
            arg_start <= req.data.range_base;
            arg_size  <= req.data.range_size;
            arg_end   <= req.data.range_base + req.data.range_size;
            idx       <= req.data.entry_index;
            stat      <= ST_OK;
            p         <= '0;
            w         <= '0;
            vc        <= count;
            unique case (req.data.op)
              OP_ADD:    state <= S_CV_RD;
              OP_APPEND: state <= S_APP;
              OP_SORT:   state <= S_SO_IRD;
              OP_FIXUP:  state <= S_FX_RD;
              OP_READ:   state <= S_RD_RD;
              OP_CLEAR: begin
                count <= '0;
                state <= S_DONE;
              end
              default:   state <= S_DONE;
            endcase
          end
        end
        // Carve: each entry turns into none, one or two entries of the other bank.
        S_CV_RD: begin
          if (p == count) begin
            count <= w;
            bank  <= ~bank;
            state <= S_APP;
          end else begin
            state <= S_CV_LD;
          end
        end
        S_CV_LD: begin
          a     <= rd;
          a_end <= ev.rd_end;
          state <= S_CV_DC;
        end
        S_CV_DC: begin
          if (ev.del) begin
            vc    <= vc - CW'(1);
            p     <= p + CW'(1);
            state <= S_CV_RD;
          end else if (ev.split && (vc != CW'(MAX_ENTRIES))) begin
            state <= S_CV_UP;
          end else begin
            if (ev.split) begin
              stat <= ST_FULL;
            end
            w     <= w + CW'(1);
            p     <= p + CW'(1);
            state <= S_CV_RD;
          end
        end
        S_CV_UP: begin
          w     <= w + CW'(2);
          vc    <= vc + CW'(1);
          p     <= p + CW'(1);
          state <= S_CV_RD;
        end
        S_APP: begin
          if (count < CW'(MAX_ENTRIES)) begin
            count <= count + CW'(1);
          end else begin
            stat <= ST_FULL;
          end
          p     <= '0;
          state <= (op == OP_ADD) ? S_SO_IRD : S_DONE;
        end
        // Selection sort: the holder keeps the smallest start seen so far.
        S_SO_IRD: begin
          if (p_inc >= {1'b0, count}) begin
            state <= S_MG_RD0;
          end else begin
            state <= S_SO_ILD;
          end
        end
        S_SO_ILD: begin
          h     <= rd;
          j     <= p + CW'(1);
          state <= S_SO_JRD;
        end
        S_SO_JRD: begin
          if (j == count) begin
            p     <= p + CW'(1);
            state <= S_SO_IRD;
          end else begin
            state <= S_SO_JLD;
          end
        end
        S_SO_JLD: begin
          a     <= rd;
          state <= S_SO_JDC;
        end
        S_SO_JDC: begin
          if (ev.lt) begin
            h <= a;
          end
          j     <= j + CW'(1);
          state <= S_SO_JRD;
        end
        // Merge compacts in place: w trails the read pointer p.
        S_MG_RD0: begin
          state <= (count < CW'(2)) ? S_DONE : S_MG_LD0;
        end
        S_MG_LD0: begin
          h     <= rd;
          h_end <= ev.rd_end;
          p     <= CW'(1);
          w     <= '0;
          state <= S_MG_RD;
        end
        S_MG_RD: begin
          if (p == count) begin
            count <= w + CW'(1);
            state <= S_DONE;
          end else begin
            state <= S_MG_LD;
          end
        end
        S_MG_LD: begin
          a     <= rd;
          a_end <= ev.rd_end;
          state <= S_MG_DC;
        end
        S_MG_DC: begin
          if (ev.merge) begin
            h_end <= ev.merged_end;
          end else begin
            w     <= w + CW'(1);
            h     <= a;
            h_end <= a_end;
          end
          p     <= p + CW'(1);
          state <= S_MG_RD;
        end
        S_FX_RD: begin
          state <= (p == count) ? S_DONE : S_FX_LD;
        end
        S_FX_LD: begin
          a     <= rd;
          a_end <= ev.rd_end;
          state <= S_FX_DC;
        end
        S_FX_DC: begin
          p     <= p + CW'(1);
          state <= S_FX_RD;
        end
        S_RD_RD: begin
          if (idx_x < count_x) begin
            state <= S_RD_LD;
          end else begin
            stat  <= ST_RANGE;
            state <= S_DONE;
          end
        end
        S_RD_LD: begin
          a     <= rd;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The result word is built as it moves into the output register.
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!rsp_valid || rsp.ready)) begin
      if ((op == OP_READ) && (stat == ST_OK)) begin
        rsp_data.entry_base <= a.start;
        rsp_data.entry_size <= a.size;
        rsp_data.entry_type <= a.mtype;
      end else begin
        rsp_data.entry_base <= '0;
        rsp_data.entry_size <= '0;
        rsp_data.entry_type <= '0;
      end
      rsp_data.entry_count <= count_w[5:0];
      rsp_data.status      <= stat;
    end
  end
endmodule

// ----- rtl/mrme_ram.sv -----
module mrme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/mrme_eval.sv -----
module mrme_eval (
  input  mrme_pkg::entry_t rd,
  input  mrme_pkg::entry_t a,
  input  logic [63:0]      a_end,
  input  mrme_pkg::entry_t h,
  input  logic [63:0]      h_end,
  input  logic [63:0]      arg_start,
  input  logic [63:0]      arg_end,
  output mrme_pkg::eval_t  ev
);
  import mrme_pkg::*;

  logic front, back;

  always_comb begin
    ev.rd_end = rd.start + rd.size;

    // Carving the new range out of entry a.
    ev.del   = (arg_start <= a.start) && (arg_end >= a_end);
    ev.split = !ev.del && (arg_start > a.start) && (arg_end < a_end);
    front    = !ev.del && !ev.split && (arg_start <= a.start) && (arg_end > a.start);
    back     = !ev.del && !ev.split && !front && (arg_start < a_end) &&
               (arg_start > a.start);
    ev.lower = a;
    if (ev.split || back) begin
      ev.lower.size = arg_start - a.start;
    end else if (front) begin
      ev.lower.start = arg_end;
      ev.lower.size  = a_end - arg_end;
    end
    ev.upper.mtype = a.mtype;
    ev.upper.start = arg_end;
    ev.upper.size  = a_end - arg_end;

    // Reserve fix-up: grow an entry ending at the start, or move one starting there.
    ev.fix = a;
    if (a_end == arg_start) begin
      ev.fix.size = arg_end - a.start;
    end else if (a.start == arg_start) begin
      ev.fix.start = arg_end;
      ev.fix.size  = a_end - arg_end;
    end

    ev.merge = (h.mtype == a.mtype) && (h.start <= a.start) && (h_end > a.start);
    ev.merged_end = (a_end > h_end) ? a_end : h_end;

    ev.lt = a.start < h.start;
  end
endmodule

// ----- rtl/mrme_chk.sv -----
module mrme_chk (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [63:0] entry_base,
  input logic [63:0] entry_size,
  input logic [7:0]  entry_type,
  input logic [1:0]  status
);
  import mrme_pkg::*;

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(entry_base))
    else $error("result word changed while stalled");

  // One word at a time: the block is busy right after taking one.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("input taken while busy");

  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status != 2'd3)
    else $error("undefined status code");

  // A read beyond the count returns zeros.
  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_RANGE) |->
      (entry_base == '0) && (entry_size == '0) && (entry_type == '0))
    else $error("out of range read returned data");

  a_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp_valid)
    else $error("result word valid after reset");
endmodule

bind memory_range_map_engine_core mrme_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .entry_base  (rsp.data.entry_base),
  .entry_size  (rsp.data.entry_size),
  .entry_type  (rsp.data.entry_type),
  .status      (rsp.data.status)
);
